// File: rtl/road_ring_phase_tracker_macros.svh
// Assertion macros shared by the ring phase tracker RTL.
`ifndef ROAD_RING_PHASE_TRACKER_MACROS_SVH
`define ROAD_RING_PHASE_TRACKER_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, checked out of reset.
`define RRPT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked out of reset.
`define RRPT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define RRPT_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define RRPT_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// File: rtl/rrpt_pkg.sv
// Shared types and codes for the ring phase tracker.
`default_nettype none

package rrpt_pkg;

    // Phase codes
    localparam logic [2:0] PH_NOT_FOUND  = 3'd0;
    localparam logic [2:0] PH_DISCOVERED = 3'd1;
    localparam logic [2:0] PH_PREP_ENTER = 3'd2;
    localparam logic [2:0] PH_PREP_EXIT  = 3'd3;
    localparam logic [2:0] PH_ABOUT_EXIT = 3'd4;
    localparam logic [2:0] PH_EXITING    = 3'd5;

    // Ring side codes
    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_LEFT  = 2'd1;
    localparam logic [1:0] KIND_RIGHT = 2'd2;

    // Configuration defaults
    localparam int         COUNT_BITS_DEF = 8;
    localparam logic [7:0] CONFIRM_RESET  = 8'd20;

    // Register map: paddr[2] selects the register word
    localparam int         ADDR_BITS   = 3;
    localparam logic       REG_CONFIRM = 1'b0;

    // Endpoint count that marks a two-way split
    localparam logic [7:0] DUAL_MIN = 8'd2;

    typedef struct packed {
        logic       ring_seen;
        logic       ring_on_left;
        logic [7:0] branch_total;
        logic [7:0] endpoint_total;
    } item_t;

    typedef struct packed {
        logic [2:0] phase;
        logic [1:0] ring_kind;
        logic       phase_changed;
    } result_t;

endpackage

`default_nettype wire

// File: rtl/rrpt_cfg.sv
// APB register block holding the confirm threshold.
`default_nettype none

module rrpt_cfg (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [rrpt_pkg::ADDR_BITS-1:0] paddr,
    input  wire logic [31:0]                   pwdata,
    output logic      [31:0]                   prdata,
    output logic                               pready,
    output logic      [7:0]                    confirm_frames
);
    import rrpt_pkg::*;

    logic [7:0] confirm_reg;
    logic       wr_hit;

    assign pready = 1'b1;
    assign wr_hit = psel && penable && pwrite && (paddr[2] == REG_CONFIRM);

    // Threshold register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            confirm_reg <= CONFIRM_RESET;
        end
        else if (wr_hit)
        begin
            confirm_reg <= pwdata[7:0];
        end
    end

    // Read mux; unused low address bits are ignored
    always_comb
    begin
        prdata = 32'd0;
        if (paddr[2] == REG_CONFIRM)
        begin
            prdata = {24'd0, confirm_reg};
        end
    end

    assign confirm_frames = confirm_reg;

endmodule

`default_nettype wire

// File: rtl/rrpt_core.sv
// Phase state machine with debounce run counters.
`default_nettype none
`include "road_ring_phase_tracker_macros.svh"

module rrpt_core #(
    parameter int COUNT_BITS = rrpt_pkg::COUNT_BITS_DEF
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            step_en,
    input  wire rrpt_pkg::item_t item,
    input  wire logic [7:0]      confirm_frames,
    output rrpt_pkg::result_t    result
);
    import rrpt_pkg::*;

    localparam int CMP_W = (COUNT_BITS > 8) ? COUNT_BITS : 8;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0] CNT_ZERO = {COUNT_BITS{1'b0}};

    function automatic logic [COUNT_BITS-1:0] bump(input logic [COUNT_BITS-1:0] c);
        return (c == CNT_MAX) ? c : COUNT_BITS'(c + 1'b1);
    endfunction

    logic [2:0]            phase_reg, phase_next;
    logic [1:0]            kind_reg, kind_next;
    logic [COUNT_BITS-1:0] seen_run_reg, seen_run_next;
    logic [COUNT_BITS-1:0] gone_run_reg, gone_run_next;
    logic [COUNT_BITS-1:0] single_run_reg, single_run_next;
    logic [COUNT_BITS-1:0] dual_run_reg, dual_run_next;

    logic [COUNT_BITS-1:0] seen_inc, gone_inc, single_inc, dual_inc;
    logic                  seen_hit, gone_hit, single_hit, dual_hit;
    logic [CMP_W-1:0]      thr_ext;
    logic [1:0]            side;
    logic                  is_single;
    logic                  ep_dual;

    // Incremented runs and threshold compares (zero threshold acts as one)
    assign seen_inc   = bump(seen_run_reg);
    assign gone_inc   = bump(gone_run_reg);
    assign single_inc = bump(single_run_reg);
    assign dual_inc   = bump(dual_run_reg);
    assign thr_ext    = CMP_W'(confirm_frames);
    assign seen_hit   = CMP_W'(seen_inc) >= thr_ext;
    assign gone_hit   = CMP_W'(gone_inc) >= thr_ext;
    assign single_hit = CMP_W'(single_inc) >= thr_ext;
    assign dual_hit   = CMP_W'(dual_inc) >= thr_ext;

    assign side      = item.ring_on_left ? KIND_LEFT : KIND_RIGHT;
    assign is_single = (item.branch_total == 8'd1) && (item.endpoint_total == 8'd1);
    assign ep_dual   = item.endpoint_total >= DUAL_MIN;

    // Next-state logic per phase
    always_comb
    begin
        phase_next      = phase_reg;
        kind_next       = kind_reg;
        seen_run_next   = seen_run_reg;
        gone_run_next   = gone_run_reg;
        single_run_next = single_run_reg;
        dual_run_next   = dual_run_reg;
        unique case (phase_reg)
            PH_NOT_FOUND:
            begin
                if (item.ring_seen)
                begin
                    gone_run_next = CNT_ZERO;
                    if (seen_hit)
                    begin
                        phase_next    = PH_DISCOVERED;
                        kind_next     = side;
                        seen_run_next = CNT_ZERO;
                    end
                    else
                    begin
                        seen_run_next = seen_inc;
                    end
                end
                else
                begin
                    seen_run_next = CNT_ZERO;
                end
            end
            PH_DISCOVERED:
            begin
                if (!item.ring_seen)
                begin
                    seen_run_next = CNT_ZERO;
                    if (gone_hit)
                    begin
                        phase_next    = PH_PREP_ENTER;
                        gone_run_next = CNT_ZERO;
                    end
                    else
                    begin
                        gone_run_next = gone_inc;
                    end
                end
                else
                begin
                    gone_run_next = CNT_ZERO;
                    kind_next     = side;
                end
            end
            PH_PREP_ENTER, PH_ABOUT_EXIT:
            begin
                if (is_single)
                begin
                    dual_run_next = CNT_ZERO;
                    if (single_hit)
                    begin
                        single_run_next = CNT_ZERO;
                        if (phase_reg == PH_PREP_ENTER)
                        begin
                            phase_next = PH_PREP_EXIT;
                        end
                        else
                        begin
                            phase_next = PH_EXITING;
                            kind_next  = KIND_NONE;
                        end
                    end
                    else
                    begin
                        single_run_next = single_inc;
                    end
                end
                else
                begin
                    single_run_next = CNT_ZERO;
                end
            end
            PH_PREP_EXIT:
            begin
                if (ep_dual)
                begin
                    single_run_next = CNT_ZERO;
                    if (dual_hit)
                    begin
                        phase_next    = PH_ABOUT_EXIT;
                        dual_run_next = CNT_ZERO;
                    end
                    else
                    begin
                        dual_run_next = dual_inc;
                    end
                end
                else
                begin
                    dual_run_next = CNT_ZERO;
                end
            end
            PH_EXITING:
            begin
                if (ep_dual)
                begin
                    dual_run_next = CNT_ZERO;
                    if (single_hit)
                    begin
                        phase_next      = PH_NOT_FOUND;
                        kind_next       = KIND_NONE;
                        single_run_next = CNT_ZERO;
                    end
                    else
                    begin
                        single_run_next = single_inc;
                    end
                end
                else
                begin
                    single_run_next = CNT_ZERO;
                end
            end
            default:
            begin
                // unreachable codes hold everything
            end
        endcase
    end

    // State registers, updated once per frame
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_NOT_FOUND;
            kind_reg       <= KIND_NONE;
            seen_run_reg   <= CNT_ZERO;
            gone_run_reg   <= CNT_ZERO;
            single_run_reg <= CNT_ZERO;
            dual_run_reg   <= CNT_ZERO;
        end
        else if (step_en)
        begin
            phase_reg      <= phase_next;
            kind_reg       <= kind_next;
            seen_run_reg   <= seen_run_next;
            gone_run_reg   <= gone_run_next;
            single_run_reg <= single_run_next;
            dual_run_reg   <= dual_run_next;
        end
    end

    assign result.phase         = phase_next;
    assign result.ring_kind     = kind_next;
    assign result.phase_changed = (phase_next != phase_reg);

    // Side is cleared outside the ring and set to left or right inside it
    `RRPT_ASSERT_IMP(a_kind_none_outside, clk, rst_n,
        (phase_reg == PH_NOT_FOUND) || (phase_reg == PH_EXITING), kind_reg == KIND_NONE)
    `RRPT_ASSERT_IMP(a_kind_set_inside, clk, rst_n,
        (phase_reg != PH_NOT_FOUND) && (phase_reg != PH_EXITING),
        (kind_reg == KIND_LEFT) || (kind_reg == KIND_RIGHT))
    `RRPT_ASSERT_IMP(a_phase_legal, clk, rst_n, 1'b1, phase_reg <= PH_EXITING)

endmodule

`default_nettype wire

// File: rtl/road_ring_phase_tracker.sv
// Top level of the debounced ring phase tracker.
// Usage:
//   Input channel: one word per video frame (ring_seen, ring_on_left,
//   branch_total, endpoint_total), taken when in_valid is high and in_stall
//   is low. Output channel: one word per input word (phase, ring_kind,
//   phase_changed), taken when out_valid is high and out_stall is low.
//   A taken input word passes the input register, then the result register,
//   and moves on only when the result register is free. Throughput:
//   one word per cycle while the receiver does not stall; the phase update
//   is a single pass of compare-and-select logic between the input register
//   and the result register.
//   The user must write the confirm_frames threshold over the APB port while
//   idle; the block does not enforce it. Reset puts the phase at not found,
//   the side at none, clears all run counters, loads confirm_frames with 20.
//   When the receiver stalls, the result register holds its word and one
//   more word waits in the input register; in_stall then rises until the
//   result is taken.
`default_nettype none
`include "road_ring_phase_tracker_macros.svh"

module road_ring_phase_tracker #(
    parameter int COUNT_BITS = rrpt_pkg::COUNT_BITS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // input channel
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic                           ring_seen,
    input  wire logic                           ring_on_left,
    input  wire logic [7:0]                     branch_total,
    input  wire logic [7:0]                     endpoint_total,
    // output channel
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic      [2:0]                     phase,
    output logic      [1:0]                     ring_kind,
    output logic                                phase_changed,
    // configuration port
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [rrpt_pkg::ADDR_BITS-1:0] paddr,
    input  wire logic [31:0]                    pwdata,
    output logic      [31:0]                    prdata,
    output logic                                pready
);
    import rrpt_pkg::*;

    logic       in_valid_reg;
    item_t      item_reg;
    logic       out_valid_reg;
    result_t    result_reg;
    result_t    result_c;
    logic [7:0] confirm_frames;
    logic       out_free;
    logic       step_move;
    logic       in_take;

    // Handshake: the result register frees when empty or being taken
    assign out_free  = !out_valid_reg || !out_stall;
    assign step_move = in_valid_reg && out_free;
    assign in_stall  = in_valid_reg && !out_free;
    assign in_take   = in_valid && !in_stall;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (step_move)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg <= '{ring_seen, ring_on_left, branch_total, endpoint_total};
        end
    end

    rrpt_cfg u_cfg (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .confirm_frames (confirm_frames)
    );

    rrpt_core #(
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .step_en        (step_move),
        .item           (item_reg),
        .confirm_frames (confirm_frames),
        .result         (result_c)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step_move)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_move)
        begin
            result_reg <= result_c;
        end
    end

    assign out_valid     = out_valid_reg;
    assign phase         = result_reg.phase;
    assign ring_kind     = result_reg.ring_kind;
    assign phase_changed = result_reg.phase_changed;

    // A processed word always lands in the result register
    `RRPT_ASSERT_NXT(a_step_lands, clk, rst_n, step_move, out_valid_reg)
    // A taken result with nothing behind it empties the register
    `RRPT_ASSERT_NXT(a_drain, clk, rst_n,
        out_valid_reg && !out_stall && !step_move, !out_valid_reg)
    // Input stalls only with both registers full and the receiver holding off
    `RRPT_ASSERT_IMP(a_stall_only_full, clk, rst_n,
        in_stall, in_valid_reg && out_valid_reg && out_stall)

endmodule

`default_nettype wire

// File: tb/tb_road_ring_phase_tracker.sv
// Self-checking testbench for the ring phase tracker: directed walks, random frames, stalls.
`timescale 1ns / 1ps

module tb_road_ring_phase_tracker;
    import rrpt_pkg::*;

    localparam int RUN_BITS    = COUNT_BITS_DEF;
    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_CYCLES = 200;
    localparam logic [ADDR_BITS-1:0] CONFIRM_ADDR = {REG_CONFIRM, 2'b00};

    // DUT-facing signals; those the bench drives are known from time zero
    logic                 clk;
    logic                 rst_n          = 1'b0;
    logic                 in_valid       = 1'b0;
    logic                 in_stall;
    logic                 ring_seen      = 1'b0;
    logic                 ring_on_left   = 1'b0;
    logic [7:0]           branch_total   = 8'd0;
    logic [7:0]           endpoint_total = 8'd0;
    logic                 out_valid;
    logic                 out_stall      = 1'b0;
    logic [2:0]           phase;
    logic [1:0]           ring_kind;
    logic                 phase_changed;
    logic                 psel           = 1'b0;
    logic                 penable        = 1'b0;
    logic                 pwrite         = 1'b0;
    logic [ADDR_BITS-1:0] paddr          = '0;
    logic [31:0]          pwdata         = '0;
    logic [31:0]          prdata;
    logic                 pready;

    // Tracker model state, reset values
    logic [2:0]          trk_phase     = PH_NOT_FOUND;
    logic [1:0]          trk_kind      = KIND_NONE;
    logic [RUN_BITS-1:0] seen_frames   = '0;
    logic [RUN_BITS-1:0] gone_frames   = '0;
    logic [RUN_BITS-1:0] single_frames = '0;
    logic [RUN_BITS-1:0] dual_frames   = '0;
    logic [7:0]          confirm_thr   = CONFIRM_RESET;

    result_t phase_words_due[$];
    int      mismatch_count = 0;
    int      quiet_cycles   = 0;
    bit      steady_flow    = 1'b0;
    int      hold_req       = 0;
    int      hold_left      = 0;
    int      run_left       = 0;
    bit      run_on         = 1'b0;

    road_ring_phase_tracker u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .ring_seen      (ring_seen),
        .ring_on_left   (ring_on_left),
        .branch_total   (branch_total),
        .endpoint_total (endpoint_total),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .phase          (phase),
        .ring_kind      (ring_kind),
        .phase_changed  (phase_changed),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    // 10 ns clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    task automatic flag_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        if (mismatch_count <= 50)
            $display("[%0t] mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
    endtask

    function automatic logic [RUN_BITS-1:0] sat_inc(input logic [RUN_BITS-1:0] c);
        return (&c) ? c : c + 1'b1;
    endfunction

    // Debounced phase update for one frame; returns the word the block should emit
    function automatic result_t next_phase_word(input item_t w);
        logic [2:0] was;
        logic [1:0] side;
        logic       single;
        result_t    r;
        was    = trk_phase;
        side   = w.ring_on_left ? KIND_LEFT : KIND_RIGHT;
        single = (w.branch_total == 8'd1) && (w.endpoint_total == 8'd1);
        case (trk_phase)
            PH_NOT_FOUND:
            begin
                if (w.ring_seen)
                begin
                    seen_frames = sat_inc(seen_frames);
                    gone_frames = '0;
                    if (seen_frames >= confirm_thr)
                    begin
                        trk_phase   = PH_DISCOVERED;
                        trk_kind    = side;
                        seen_frames = '0;
                    end
                end
                else
                    seen_frames = '0;
            end
            PH_DISCOVERED:
            begin
                if (!w.ring_seen)
                begin
                    gone_frames = sat_inc(gone_frames);
                    seen_frames = '0;
                    if (gone_frames >= confirm_thr)
                    begin
                        trk_phase   = PH_PREP_ENTER;
                        gone_frames = '0;
                    end
                end
                else
                begin
                    gone_frames = '0;
                    trk_kind    = side;
                end
            end
            PH_PREP_ENTER, PH_ABOUT_EXIT:
            begin
                if (single)
                begin
                    single_frames = sat_inc(single_frames);
                    dual_frames   = '0;
                    if (single_frames >= confirm_thr)
                    begin
                        if (trk_phase == PH_PREP_ENTER)
                            trk_phase = PH_PREP_EXIT;
                        else
                        begin
                            trk_phase = PH_EXITING;
                            trk_kind  = KIND_NONE;
                        end
                        single_frames = '0;
                    end
                end
                else
                    single_frames = '0;
            end
            PH_PREP_EXIT:
            begin
                if (w.endpoint_total >= DUAL_MIN)
                begin
                    dual_frames   = sat_inc(dual_frames);
                    single_frames = '0;
                    if (dual_frames >= confirm_thr)
                    begin
                        trk_phase   = PH_ABOUT_EXIT;
                        dual_frames = '0;
                    end
                end
                else
                    dual_frames = '0;
            end
            PH_EXITING:
            begin
                if (w.endpoint_total > 8'd1)
                begin
                    single_frames = sat_inc(single_frames);
                    dual_frames   = '0;
                    if (single_frames >= confirm_thr)
                    begin
                        trk_phase     = PH_NOT_FOUND;
                        trk_kind      = KIND_NONE;
                        single_frames = '0;
                    end
                end
                else
                    single_frames = '0;
            end
            default:
            begin
            end
        endcase
        r.phase         = trk_phase;
        r.ring_kind     = trk_kind;
        r.phase_changed = (trk_phase != was);
        return r;
    endfunction

    // Config tracking, result checking, then prediction for the word taken this edge
    always @(posedge clk)
    begin
        result_t want;
        item_t   taken;
        if (rst_n)
        begin
            if (psel && penable && pwrite && pready && paddr == CONFIRM_ADDR)
                confirm_thr = pwdata[7:0];
            if (out_valid && !out_stall)
            begin
                if (phase_words_due.size() == 0)
                    flag_mismatch("word with nothing due (phase)", int'(phase), -1);
                else
                begin
                    want = phase_words_due.pop_front();
                    if (phase !== want.phase)
                        flag_mismatch("phase", int'(phase), int'(want.phase));
                    if (ring_kind !== want.ring_kind)
                        flag_mismatch("ring_kind", int'(ring_kind), int'(want.ring_kind));
                    if (phase_changed !== want.phase_changed)
                        flag_mismatch("phase_changed", int'(phase_changed),
                                      int'(want.phase_changed));
                end
            end
            if (in_valid && !in_stall)
            begin
                taken.ring_seen      = ring_seen;
                taken.ring_on_left   = ring_on_left;
                taken.branch_total   = branch_total;
                taken.endpoint_total = endpoint_total;
                phase_words_due = {phase_words_due, next_phase_word(taken)};
            end
        end
    end

    // Watchdog: cycles with no word moving on either side
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // Receiver: long hold on request, no stall in steady flow, else random stall runs
    always @(negedge clk)
    begin
        if (hold_req != 0)
        begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (!rst_n)
            out_stall <= 1'b0;
        else if (hold_left != 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (steady_flow)
            out_stall <= 1'b0;
        else
        begin
            if (run_left == 0)
            begin
                run_on   = ($urandom_range(0, 99) < 35);
                run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                       : $urandom_range(1, 4);
            end
            run_left--;
            out_stall <= run_on;
        end
    end

    function automatic int pick_gap();
        int r;
        if (steady_flow)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(6, 25);
    endfunction

    function automatic item_t frame(input logic s, input logic l,
                                    input logic [7:0] b, input logic [7:0] e);
        item_t w;
        w.ring_seen      = s;
        w.ring_on_left   = l;
        w.branch_total   = b;
        w.endpoint_total = e;
        return w;
    endfunction

    function automatic item_t rand_frame();
        return frame(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                     8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    endfunction

    // Frame that mostly meets the current phase's condition, sometimes breaks it
    function automatic item_t pick_frame(input int noise_pct, input int break_pct);
        item_t w;
        int    r;
        bit    brk;
        w = rand_frame();
        r = $urandom_range(0, 99);
        if (r < noise_pct)
            return w;
        brk = (r < noise_pct + break_pct);
        case (trk_phase)
            PH_NOT_FOUND:
                w.ring_seen = !brk;
            PH_DISCOVERED:
                w.ring_seen = brk;
            PH_PREP_ENTER, PH_ABOUT_EXIT:
            begin
                if (!brk)
                begin
                    w.branch_total   = 8'd1;
                    w.endpoint_total = 8'd1;
                end
                else
                begin
                    case ($urandom_range(0, 2))
                        0: w.endpoint_total = 8'd0;
                        1:
                        begin
                            w.branch_total   = 8'd1;
                            w.endpoint_total = 8'($urandom_range(2, 255));
                        end
                        default:
                        begin
                            w.endpoint_total = 8'd1;
                            w.branch_total   = $urandom_range(0, 1) ? 8'd0
                                                                    : 8'($urandom_range(2, 255));
                        end
                    endcase
                end
            end
            PH_PREP_EXIT, PH_EXITING:
                w.endpoint_total = brk ? 8'($urandom_range(0, 1))
                                       : 8'($urandom_range(2, 255));
            default:
            begin
            end
        endcase
        return w;
    endfunction

    // Offer one word and hold it until taken
    task automatic send_frame(input item_t w);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid       <= 1'b1;
        ring_seen      <= w.ring_seen;
        ring_on_left   <= w.ring_on_left;
        branch_total   <= w.branch_total;
        endpoint_total <= w.endpoint_total;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        // let the model catch up with the word just taken
        #1;
    endtask

    // Stop offering and wait for every due word, plus pipeline tail
    task automatic settle_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (phase_words_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic check_confirm(input logic [7:0] v);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= CONFIRM_ADDR;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== 32'(v))
            flag_mismatch("confirm_frames readback", int'(prdata), int'(v));
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic write_confirm(input logic [7:0] v);
        settle_idle();
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CONFIRM_ADDR;
        pwdata  <= 32'(v);
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        check_confirm(v);
    endtask

    // Reset threshold, field extremes, no move expected
    task automatic test_reset_state();
        check_confirm(CONFIRM_RESET);
        send_frame(frame(1'b0, 1'b0, 8'd0, 8'd0));
        send_frame(frame(1'b1, 1'b1, 8'd255, 8'd255));
        send_frame(frame(1'b0, 1'b1, 8'd255, 8'd0));
        send_frame(frame(1'b1, 1'b0, 8'd0, 8'd255));
        send_frame(frame(1'b1, 1'b1, 8'd1, 8'd1));
        send_frame(frame(1'b0, 1'b0, 8'd1, 8'd1));
    endtask

    // Full ring at threshold 1, zero threshold, then threshold 2 with a broken run
    task automatic test_ring_walk();
        write_confirm(8'd1);
        send_frame(frame(1'b1, 1'b1, 8'd0, 8'd0));    // discovered, left
        send_frame(frame(1'b1, 1'b0, 8'd7, 8'd3));    // side refresh to right
        send_frame(frame(1'b0, 1'b1, 8'd1, 8'd1));    // prepare enter
        send_frame(frame(1'b1, 1'b0, 8'd1, 8'd1));    // prepare exit
        send_frame(frame(1'b0, 1'b0, 8'd5, 8'd1));    // one endpoint: stays
        send_frame(frame(1'b0, 1'b0, 8'd1, 8'd2));    // about to exit
        send_frame(frame(1'b0, 1'b0, 8'd1, 8'd0));    // not single: stays
        send_frame(frame(1'b1, 1'b1, 8'd1, 8'd1));    // exiting, side cleared
        send_frame(frame(1'b0, 1'b0, 8'd0, 8'd255));  // back to not found
        write_confirm(8'd0);
        send_frame(frame(1'b1, 1'b0, 8'd255, 8'd255));
        send_frame(frame(1'b0, 1'b1, 8'd0, 8'd0));
        send_frame(frame(1'b0, 1'b0, 8'd1, 8'd1));
        send_frame(frame(1'b1, 1'b1, 8'd0, 8'd255));
        send_frame(frame(1'b1, 1'b0, 8'd1, 8'd1));
        send_frame(frame(1'b0, 1'b1, 8'd9, 8'd2));
        write_confirm(8'd2);
        send_frame(frame(1'b1, 1'b1, 8'd3, 8'd3));
        send_frame(frame(1'b0, 1'b1, 8'd3, 8'd3));    // breaks the seen run
        send_frame(frame(1'b1, 1'b1, 8'd3, 8'd3));
        send_frame(frame(1'b1, 1'b0, 8'd3, 8'd3));    // discovered, right
    endtask

    // Largest threshold: the move lands exactly on the 255th frame
    task automatic test_threshold_extremes();
        write_confirm(8'd255);
        settle_idle();
        // starts in discovered, so ring-absent frames build the gone run
        for (int i = 0; i < 255; i++)
            send_frame(frame(1'b0, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                             8'($urandom_range(0, 255))));
        for (int i = 0; i < 20; i++)
            send_frame(pick_frame(30, 10));
    endtask

    // Receiver holds off long while the sender keeps offering
    task automatic test_backpressure();
        write_confirm(8'd3);
        steady_flow = 1'b1;
        hold_req    = HOLD_CYCLES;
        for (int i = 0; i < 40; i++)
            send_frame(pick_frame(5, 5));
        steady_flow = 1'b0;
    endtask

    // Well-formed ring walks with random content across several thresholds
    task automatic test_random_walks();
        logic [7:0] thr_list[6];
        thr_list = '{8'd1, 8'd2, 8'd3, 8'd4, 8'd0, 8'd0};
        thr_list[5] = 8'($urandom_range(2, 6));
        foreach (thr_list[k])
        begin
            write_confirm(thr_list[k]);
            for (int i = 0; i < 220; i++)
            begin
                if (i % 64 == 0)
                    steady_flow = ($urandom_range(0, 4) == 0);
                send_frame(pick_frame(5, 5));
            end
            steady_flow = 1'b0;
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_reset_state();
        test_ring_walk();
        test_threshold_extremes();
        test_backpressure();
        test_random_walks();
        settle_idle();
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl
rtl/rrpt_pkg.sv
rtl/rrpt_cfg.sv
rtl/rrpt_core.sv
rtl/road_ring_phase_tracker.sv
tb/tb_road_ring_phase_tracker.sv
